// ===== src/cps_pkg.sv =====
`timescale 1ns / 1ps
package cps_pkg;

  // position fields travel at the widest column or row index
  localparam int POS_W = 12;
  // working width for the +/- offsets on the result fields
  localparam int EXT_W = 13;

  // command queue between scanner and emitter
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  typedef struct packed {
    logic             has_box;
    logic             is_end;
    logic             fail;
    logic [POS_W-1:0] start_col;
    logic [POS_W-1:0] end_col;
    logic [POS_W-1:0] first_row;
    logic [POS_W-1:0] last_row;
  } cmd_t;

endpackage

// ===== src/column_projection_segmenter_top.sv =====
`timescale 1ns / 1ps
// pixels: one transaction per cycle while in_stall is low; the scanner updates its column state on every accepted pixel
// results: nothing until the image-end pixel; its command goes through the queue, and a status result
// is then registered at the outputs, while each box in turn passes S_READ (registered store read) and S_LOAD
// a full 4-entry command queue stalls the pixel side while the previous image drains
// rst (synchronous, active high) clears all control state; box store contents are kept
module column_projection_segmenter_top import cps_pkg::*; #(
  parameter int MAX_ROWS     = 1024,
  parameter int MAX_COLS     = 1024,
  parameter int MAX_SEGMENTS = 8
) (
  input  logic               clk,
  input  logic               rst,
  // pixel channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         bin_pixel,
  input  logic [7:0]         raw_pixel,
  input  logic               column_end,
  input  logic               image_end,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               seg_valid,
  output logic signed [11:0] left_col,
  output logic [10:0]        right_col,
  output logic signed [10:0] top_row,
  output logic [10:0]        bottom_row,
  output logic               failed,
  output logic               last
);

  // scanner -> queue -> emitter
  cmd_t push_cmd, head_cmd;
  logic push, pop, q_full, q_empty;

  // column scanner: tracks column projections, opens and closes segments,
  // and queues one command per kept box and per image end; a box closed by the image end shares its command
  cps_front #(
    .MAX_ROWS     (MAX_ROWS),
    .MAX_COLS     (MAX_COLS),
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .bin_pixel  (bin_pixel),
    .raw_pixel  (raw_pixel),
    .column_end (column_end),
    .image_end  (image_end),
    .q_full     (q_full),
    .push       (push),
    .cmd        (push_cmd)
  );

  // short queue so the scanner can run on while results are held up
  cps_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .pop       (pop),
    .pop_data  (head_cmd),
    .full      (q_full),
    .empty     (q_empty)
  );

  // emitter: stores boxes, and at image end plays them out or gives one status result
  cps_back #(
    .MAX_ROWS     (MAX_ROWS),
    .MAX_COLS     (MAX_COLS),
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd        (head_cmd),
    .q_empty    (q_empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .seg_valid  (seg_valid),
    .left_col   (left_col),
    .right_col  (right_col),
    .top_row    (top_row),
    .bottom_row (bottom_row),
    .failed     (failed),
    .last       (last)
  );

endmodule

// ===== src/cps_front.sv =====
`timescale 1ns / 1ps
module cps_front import cps_pkg::*; #(
  parameter int MAX_ROWS     = 1024,
  parameter int MAX_COLS     = 1024,
  parameter int MAX_SEGMENTS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] bin_pixel,
  input  logic [7:0] raw_pixel,
  input  logic       column_end,
  input  logic       image_end,
  input  logic       q_full,
  output logic       push,
  output cmd_t       cmd
);

  localparam int RW  = (MAX_ROWS > 2) ? $clog2(MAX_ROWS) : 1;
  localparam int CW  = (MAX_COLS > 2) ? $clog2(MAX_COLS) : 1;
  localparam int SCW = $clog2(MAX_SEGMENTS + 1);

  typedef struct packed {
    logic          seen;
    logic [RW-1:0] first;
    logic [RW-1:0] last;
  } span_t;

  function automatic span_t merge(span_t a, span_t b);
    span_t r;
    r = a;
    if (b.seen) begin
      if (!a.seen) begin
        r = b;
      end else begin
        if (b.first < a.first) r.first = b.first;
        if (b.last > a.last) r.last = b.last;
      end
    end
    return r;
  endfunction

  logic           in_segment, in_segment_next;
  logic           col_nonwhite, col_nonwhite_next;
  logic           col_has_black, col_has_black_next;
  logic [RW-1:0]  row_count, row_count_next;
  logic [CW-1:0]  col_count, col_count_next;
  span_t          col_raw, col_raw_next;
  span_t          prev_raw, prev_raw_next;
  logic [CW-1:0]  seg_start, seg_start_next;
  span_t          box, box_next;
  logic           fail_flag, fail_flag_next;
  logic [SCW-1:0] seg_count, seg_count_next;

  logic  accept;
  logic  raw_black;
  logic  nonwhite_now, black_now;
  span_t cur, merged;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    in_segment_next    = in_segment;
    col_nonwhite_next  = col_nonwhite;
    col_has_black_next = col_has_black;
    row_count_next     = row_count;
    col_count_next     = col_count;
    col_raw_next       = col_raw;
    prev_raw_next      = prev_raw;
    seg_start_next     = seg_start;
    box_next           = box;
    fail_flag_next     = fail_flag;
    seg_count_next     = seg_count;
    push               = 1'b0;
    cmd                = '0;

    raw_black    = (raw_pixel == 8'd0);
    nonwhite_now = col_nonwhite | (bin_pixel != 8'd255);
    black_now    = col_has_black | (bin_pixel == 8'd0);
    cur.seen     = col_raw.seen | raw_black;
    cur.first    = (raw_black && !col_raw.seen) ? row_count : col_raw.first;
    cur.last     = raw_black ? row_count : col_raw.last;
    merged       = merge(box, cur);

    if (accept) begin
      col_nonwhite_next  = nonwhite_now;
      col_has_black_next = black_now;
      col_raw_next       = cur;
      if (row_count < RW'(MAX_ROWS - 1)) row_count_next = row_count + 1'b1;

      if (column_end || image_end) begin
        if (in_segment) begin
          box_next = merged;
          if (!black_now) begin
            // column with no black closes the segment
            in_segment_next = 1'b0;
            if (merged.seen && (merged.first != '0) &&
                (seg_count < SCW'(MAX_SEGMENTS))) begin
              push           = 1'b1;
              cmd.has_box    = 1'b1;
              cmd.start_col  = POS_W'(seg_start);
              cmd.end_col    = POS_W'(col_count);
              cmd.first_row  = POS_W'(merged.first);
              cmd.last_row   = POS_W'(merged.last);
              seg_count_next = seg_count + 1'b1;
            end else begin
              fail_flag_next = 1'b1;
            end
          end
        end else if (nonwhite_now) begin
          in_segment_next = 1'b1;
          seg_start_next  = col_count;
          box_next        = merge(prev_raw, cur);
        end
        prev_raw_next      = cur;
        col_raw_next       = '0;
        col_nonwhite_next  = 1'b0;
        col_has_black_next = 1'b0;
        row_count_next     = '0;
        if (col_count < CW'(MAX_COLS - 1)) col_count_next = col_count + 1'b1;
      end

      if (image_end) begin
        push       = 1'b1;
        cmd.is_end = 1'b1;
        cmd.fail   = fail_flag_next | in_segment_next;
        in_segment_next    = 1'b0;
        col_nonwhite_next  = 1'b0;
        col_has_black_next = 1'b0;
        row_count_next     = '0;
        col_count_next     = '0;
        col_raw_next       = '0;
        prev_raw_next      = '0;
        seg_start_next     = '0;
        box_next           = '0;
        fail_flag_next     = 1'b0;
        seg_count_next     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_segment    <= 1'b0;
      col_nonwhite  <= 1'b0;
      col_has_black <= 1'b0;
      row_count     <= '0;
      col_count     <= '0;
      col_raw       <= '0;
      prev_raw      <= '0;
      seg_start     <= '0;
      box           <= '0;
      fail_flag     <= 1'b0;
      seg_count     <= '0;
    end else begin
      in_segment    <= in_segment_next;
      col_nonwhite  <= col_nonwhite_next;
      col_has_black <= col_has_black_next;
      row_count     <= row_count_next;
      col_count     <= col_count_next;
      col_raw       <= col_raw_next;
      prev_raw      <= prev_raw_next;
      seg_start     <= seg_start_next;
      box           <= box_next;
      fail_flag     <= fail_flag_next;
      seg_count     <= seg_count_next;
    end
  end

endmodule

// ===== src/cps_fifo.sv =====
`timescale 1ns / 1ps
module cps_fifo import cps_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  input  logic pop,
  output cmd_t pop_data,
  output logic full,
  output logic empty
);

  cmd_t            slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr, rd_ptr;
  logic [Q_AW:0]   fill;

  assign full     = (fill == (Q_AW + 1)'(Q_DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== src/cps_back.sv =====
`timescale 1ns / 1ps
module cps_back import cps_pkg::*; #(
  parameter int MAX_ROWS     = 1024,
  parameter int MAX_COLS     = 1024,
  parameter int MAX_SEGMENTS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  logic               q_empty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               seg_valid,
  output logic signed [11:0] left_col,
  output logic [10:0]        right_col,
  output logic signed [10:0] top_row,
  output logic [10:0]        bottom_row,
  output logic               failed,
  output logic               last
);

  localparam int RW    = (MAX_ROWS > 2) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 2) ? $clog2(MAX_COLS) : 1;
  localparam int SCW   = $clog2(MAX_SEGMENTS + 1);
  localparam int SIW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int ENT_W = 2 * CW + 2 * RW;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_LOAD = 3'b100
  } state_t;

  state_t         state, state_next;
  logic [SCW-1:0] wr_cnt, wr_cnt_next;
  logic [SCW-1:0] n_total, n_total_next;
  logic [SIW-1:0] rd_idx, rd_idx_next;

  logic [ENT_W-1:0] store [MAX_SEGMENTS];
  logic [ENT_W-1:0] rdata;
  logic [ENT_W-1:0] wdata;
  logic             do_write;

  logic             out_free;
  logic             load_box, load_flag, flag_fail, is_last;
  logic [SCW-1:0]   tot;
  logic [CW-1:0]    e_start, e_end;
  logic [RW-1:0]    e_first, e_last;
  logic [EXT_W-1:0] x_left, x_right, x_top, x_bottom;

  assign out_free = !out_valid || !out_stall;
  assign wdata    = {cmd.start_col[CW-1:0], cmd.end_col[CW-1:0],
                     cmd.first_row[RW-1:0], cmd.last_row[RW-1:0]};
  assign {e_start, e_end, e_first, e_last} = rdata;
  assign is_last  = ((SCW'(rd_idx) + 1'b1) == n_total);

  // result offsets, wrapped to the port widths
  assign x_left   = EXT_W'(e_start) - EXT_W'(1);
  assign x_right  = EXT_W'(e_end) + EXT_W'(1);
  assign x_top    = EXT_W'(e_first) - EXT_W'(1);
  assign x_bottom = EXT_W'(e_last) + EXT_W'(2);

  always_comb begin
    state_next   = state;
    wr_cnt_next  = wr_cnt;
    n_total_next = n_total;
    rd_idx_next  = rd_idx;
    pop          = 1'b0;
    do_write     = 1'b0;
    load_box     = 1'b0;
    load_flag    = 1'b0;
    flag_fail    = cmd.fail;
    tot          = wr_cnt + SCW'(cmd.has_box);

    case (state)
      S_IDLE: begin
        if (!q_empty && (!cmd.is_end || out_free)) begin
          pop = 1'b1;
          if (cmd.has_box) begin
            do_write    = 1'b1;
            wr_cnt_next = tot;
          end
          if (cmd.is_end) begin
            if (cmd.fail || (tot == '0)) begin
              load_flag   = 1'b1;
              wr_cnt_next = '0;
            end else begin
              n_total_next = tot;
              rd_idx_next  = '0;
              state_next   = S_READ;
            end
          end
        end
      end
      S_READ: begin
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          load_box = 1'b1;
          if (is_last) begin
            wr_cnt_next = '0;
            state_next  = S_IDLE;
          end else begin
            rd_idx_next = rd_idx + 1'b1;
            state_next  = S_READ;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_write) store[wr_cnt[SIW-1:0]] <= wdata;
    rdata <= store[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (load_flag) begin
      seg_valid  <= 1'b0;
      left_col   <= '0;
      right_col  <= '0;
      top_row    <= '0;
      bottom_row <= '0;
      failed     <= flag_fail;
      last       <= 1'b1;
    end else if (load_box) begin
      seg_valid  <= 1'b1;
      left_col   <= x_left[11:0];
      right_col  <= x_right[10:0];
      top_row    <= x_top[10:0];
      bottom_row <= x_bottom[10:0];
      failed     <= 1'b0;
      last       <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wr_cnt    <= '0;
      n_total   <= '0;
      rd_idx    <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      wr_cnt    <= wr_cnt_next;
      n_total   <= n_total_next;
      rd_idx    <= rd_idx_next;
      if (load_flag || load_box) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== src/cps_checker.sv =====
`timescale 1ns / 1ps
module cps_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_stall,
  input logic seg_valid,
  input logic failed,
  input logic last
);

  // a held result transaction stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a status result is always the only one of its image
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !seg_valid |-> last)
    else $error("status result without last");

  // a failure never carries a box
  a_fail_nobox: assert property (@(posedge clk) disable iff (rst)
    out_valid && failed |-> !seg_valid)
    else $error("failure result carries a box");

endmodule

bind column_projection_segmenter_top cps_checker u_cps_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .seg_valid (seg_valid),
  .failed    (failed),
  .last      (last)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

  // block sizes as built with its default parameters
  localparam int ROW_LIMIT    = 1024;
  localparam int COL_LIMIT    = 1024;
  localparam int SEG_LIMIT    = 8;
  // run control
  localparam int CYCLE_LIMIT  = 500000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 16;
  localparam int PIXEL_TARGET = 460;

  // one result transaction as it leaves the block
  typedef struct packed {
    logic        seg_valid;
    logic [11:0] left_col;
    logic [10:0] right_col;
    logic [10:0] top_row;
    logic [10:0] bottom_row;
    logic        failed;
    logic        last;
  } box_result_t;

  // one pixel transaction
  typedef struct packed {
    logic [7:0] bin;
    logic [7:0] raw;
    logic       cend;
    logic       iend;
  } pixel_t;

  // what a generated column looks like
  typedef enum {COL_WHITE, COL_INK, COL_GRAY, COL_NOISE} col_kind_t;
  // deliberate defects planted in a text image
  typedef enum {FLAW_NONE, FLAW_TOP_RAW, FLAW_NO_RAW} flaw_t;

  // tracks the segmentation of the pixel stream and holds the boxes still owed
  class box_tracker;
    bit          in_seg, col_nonwhite, col_black;
    bit [9:0]    row_idx;
    bit [10:0]   col_idx;
    bit          raw_seen, prev_seen, box_seen, fail_flag;
    bit [9:0]    raw_first, raw_last, prev_first, prev_last, box_first, box_last;
    bit [10:0]   seg_start;
    int          seg_count;
    bit [10:0]   kept_start [SEG_LIMIT];
    bit [10:0]   kept_end   [SEG_LIMIT];
    bit [9:0]    kept_first [SEG_LIMIT];
    bit [9:0]    kept_last  [SEG_LIMIT];
    box_result_t pending_boxes[$];
    int          errors;

    function new();
      clear_image();
      errors = 0;
    endfunction

    function void clear_image();
      in_seg = 0; col_nonwhite = 0; col_black = 0;
      row_idx = 0; col_idx = 0;
      raw_seen = 0; raw_first = 0; raw_last = 0;
      prev_seen = 0; prev_first = 0; prev_last = 0;
      seg_start = 0;
      box_seen = 0; box_first = 0; box_last = 0;
      fail_flag = 0;
      seg_count = 0;
    endfunction

    function void merge_rows(bit seen, bit [9:0] first_row, bit [9:0] last_row);
      if (!seen) return;
      if (!box_seen) begin
        box_first = first_row;
        box_last  = last_row;
        box_seen  = 1;
      end else begin
        if (first_row < box_first) box_first = first_row;
        if (last_row > box_last) box_last = last_row;
      end
    endfunction

    function void close_segment(bit [10:0] end_col);
      in_seg = 0;
      if (!box_seen || box_first == 0 || seg_count >= SEG_LIMIT) begin
        fail_flag = 1;
        return;
      end
      kept_start[seg_count] = seg_start;
      kept_end[seg_count]   = end_col;
      kept_first[seg_count] = box_first;
      kept_last[seg_count]  = box_last;
      seg_count++;
    endfunction

    function void finish_column();
      if (in_seg) begin
        merge_rows(raw_seen, raw_first, raw_last);
        if (!col_black) close_segment(col_idx);
      end else if (col_nonwhite) begin
        in_seg    = 1;
        seg_start = col_idx;
        box_seen  = 0; box_first = 0; box_last = 0;
        merge_rows(prev_seen, prev_first, prev_last);
        merge_rows(raw_seen, raw_first, raw_last);
      end
      prev_seen  = raw_seen;
      prev_first = raw_first;
      prev_last  = raw_last;
      raw_seen = 0; raw_first = 0; raw_last = 0;
      col_nonwhite = 0; col_black = 0;
      row_idx = 0;
      if (col_idx < COL_LIMIT - 1) col_idx++;
    endfunction

    function void note_pixel(pixel_t px);
      box_result_t res;
      int          k;
      if (px.bin != 8'd255) col_nonwhite = 1;
      if (px.bin == 8'd0) col_black = 1;
      if (px.raw == 8'd0) begin
        if (!raw_seen) begin
          raw_first = row_idx;
          raw_seen  = 1;
        end
        raw_last = row_idx;
      end
      if (row_idx < ROW_LIMIT - 1) row_idx++;
      if (px.cend || px.iend) finish_column();
      if (!px.iend) return;
      if (in_seg) fail_flag = 1;
      if (fail_flag || seg_count == 0) begin
        res        = '0;
        res.failed = fail_flag;
        res.last   = 1'b1;
        pending_boxes.insert(pending_boxes.size(), res);
      end else begin
        for (k = 0; k < seg_count; k++) begin
          res            = '0;
          res.seg_valid  = 1'b1;
          res.left_col   = {1'b0, kept_start[k]} - 12'd1;
          res.right_col  = kept_end[k] + 11'd1;
          res.top_row    = {1'b0, kept_first[k]} - 11'd1;
          res.bottom_row = {1'b0, kept_last[k]} + 11'd2;
          res.last       = (k == seg_count - 1);
          pending_boxes.insert(pending_boxes.size(), res);
        end
      end
      clear_image();
    endfunction

    function void compare_field(string name, logic signed [12:0] want,
                                logic signed [12:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_box(box_result_t got);
      box_result_t want;
      if (pending_boxes.size() == 0) begin
        $display("%0t: unexpected result, seg_valid %0d left_col %0d right_col %0d",
                 $time, got.seg_valid, $signed(got.left_col), got.right_col);
        errors++;
        return;
      end
      want = pending_boxes.pop_front();
      compare_field("seg_valid", want.seg_valid, got.seg_valid);
      compare_field("left_col", $signed(want.left_col), $signed(got.left_col));
      compare_field("right_col", want.right_col, got.right_col);
      compare_field("top_row", $signed(want.top_row), $signed(got.top_row));
      compare_field("bottom_row", want.bottom_row, got.bottom_row);
      compare_field("failed", want.failed, got.failed);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         bin_pixel;
  logic [7:0]         raw_pixel;
  logic               column_end;
  logic               image_end;
  logic               out_valid;
  logic               out_stall;
  logic               seg_valid;
  logic signed [11:0] left_col;
  logic [10:0]        right_col;
  logic signed [10:0] top_row;
  logic [10:0]        bottom_row;
  logic               failed;
  logic               last;

  box_tracker tracker;
  pixel_t     image_q[$];       // pixels of the image being built
  int         send_idle;        // percent of cycles the pixel side holds back
  int         recv_idle;        // percent of cycles the result side stalls
  bit         hold_req;         // asks the result side for one long hold-off
  bit         hold_done;
  int         pixels_sent;
  int         cycle_count = 0;

  column_projection_segmenter_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .bin_pixel  (bin_pixel),
    .raw_pixel  (raw_pixel),
    .column_end (column_end),
    .image_end  (image_end),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .seg_valid  (seg_valid),
    .left_col   (left_col),
    .right_col  (right_col),
    .top_row    (top_row),
    .bottom_row (bottom_row),
    .failed     (failed),
    .last       (last)
  );

  // 8 ns clock, low half first
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // run-away guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("column_projection_segmenter_top regression: fail");
      $finish;
    end
  end

  // sample both channels at the rising edge, before the block updates
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      tracker.check_box({seg_valid, left_col, right_col, top_row, bottom_row, failed, last});
    if (!rst && in_valid && !in_stall)
      tracker.note_pixel({bin_pixel, raw_pixel, column_end, image_end});
  end

  // result side: random stalls, plus one long hold-off counted here
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        out_stall = 1'b1;
        for (n = 0; n < HOLD_CYCLES; n++) @(negedge clk);
      end
      out_stall = ($urandom_range(99) < recv_idle);
    end
  end

  // offer one pixel transaction and wait until it is taken
  task automatic send_pixel(input pixel_t px);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    bin_pixel  = px.bin;
    raw_pixel  = px.raw;
    column_end = px.cend;
    image_end  = px.iend;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    pixels_sent++;
  endtask

  task automatic send_image();
    int i;
    for (i = 0; i < image_q.size(); i++) send_pixel(image_q[i]);
    image_q.delete();
  endtask

  function automatic void add_px(logic [7:0] b, logic [7:0] r, logic ce, logic ie);
    pixel_t px;
    px = {b, r, ce, ie};
    image_q.insert(image_q.size(), px);
  endfunction

  // one column of h pixels, column_end on the bottom one
  function automatic void push_column(int h, col_kind_t kind, int ink_row, flaw_t flaw);
    pixel_t px;
    int     r;
    bit     black;
    for (r = 0; r < h; r++) begin
      px.cend = (r == h - 1);
      px.iend = 1'b0;
      // raw black only below the top row, except in noise columns or where a flaw asks for it
      px.raw  = (r > 0 && $urandom_range(99) < 10) ? 8'd0 : 8'($urandom_range(1, 255));
      case (kind)
        COL_WHITE: begin
          px.bin = 8'd255;
        end
        COL_INK: begin
          black  = (r == ink_row) || ($urandom_range(99) < 35);
          px.bin = black ? 8'd0
                 : ($urandom_range(99) < 75 ? 8'd255 : 8'($urandom_range(1, 254)));
          if (black && r > 0) px.raw = 8'd0;
        end
        COL_GRAY: begin
          px.bin = ($urandom_range(99) < 50) ? 8'd255 : 8'($urandom_range(1, 254));
        end
        default: begin
          case ($urandom_range(2))
            0: px.bin = 8'd0;
            1: px.bin = 8'd255;
            default: px.bin = 8'($urandom_range(1, 254));
          endcase
          px.raw = ($urandom_range(99) < 30) ? 8'd0 : 8'($urandom_range(0, 255));
        end
      endcase
      if (flaw == FLAW_NO_RAW && px.raw == 8'd0) px.raw = 8'($urandom_range(1, 255));
      if (flaw == FLAW_TOP_RAW && r == 0) px.raw = 8'd0;
      image_q.insert(image_q.size(), px);
    end
  endfunction

  // mark the image end, sometimes without the column end beside it
  function automatic void end_image();
    pixel_t px;
    px      = image_q.pop_back();
    px.iend = 1'b1;
    if ($urandom_range(3) == 0) px.cend = 1'b0;
    image_q.insert(image_q.size(), px);
  endfunction

  // a line of characters: inked column runs split by blank or gray columns
  function automatic void build_text(int min_chars, int max_chars, int h, flaw_t flaw,
                                     bit leave_open);
    int    n_chars, c, i, w, flawed;
    flaw_t plain, cf;
    n_chars = $urandom_range(min_chars, max_chars);
    flawed  = $urandom_range(0, n_chars - 1);
    plain   = (flaw == FLAW_NO_RAW) ? FLAW_NO_RAW : FLAW_NONE;
    repeat ($urandom_range(0, 2)) push_column(h, COL_WHITE, 0, plain);
    for (c = 0; c < n_chars; c++) begin
      w = $urandom_range(1, 3);
      for (i = 0; i < w; i++) begin
        cf = (flaw == FLAW_TOP_RAW && c == flawed && i == 0) ? FLAW_TOP_RAW : plain;
        push_column(h, COL_INK, $urandom_range(1, h - 1), cf);
      end
      if (leave_open && c == n_chars - 1) break;
      push_column(h, ($urandom_range(1) != 0) ? COL_GRAY : COL_WHITE, 0, plain);
      repeat ($urandom_range(0, 1)) push_column(h, COL_WHITE, 0, plain);
    end
    end_image();
  endfunction

  task automatic send_random_image();
    int pick, h, n;
    pick = $urandom_range(99);
    h    = $urandom_range(2, 6);
    if (pick < 64) build_text(1, SEG_LIMIT, h, FLAW_NONE, 1'b0);
    else if (pick < 71) build_text(1, 4, h, FLAW_NONE, 1'b1);
    else if (pick < 77) build_text(1, 4, h, FLAW_TOP_RAW, 1'b0);
    else if (pick < 82) build_text(1, 3, h, FLAW_NO_RAW, 1'b0);
    else if (pick < 86) build_text(SEG_LIMIT + 1, SEG_LIMIT + 2, 2, FLAW_NONE, 1'b0);
    else begin
      // unstructured noise, ragged column heights
      repeat ($urandom_range(1, 8)) push_column($urandom_range(1, 6), COL_NOISE, 0, FLAW_NONE);
      end_image();
    end
    send_image();
  endtask

  initial begin
    tracker     = new();
    rst         = 1'b1;
    in_valid    = 1'b0;
    bin_pixel   = 8'd0;
    raw_pixel   = 8'd0;
    column_end  = 1'b0;
    image_end   = 1'b0;
    send_idle   = 10;
    recv_idle   = 73;
    hold_req    = 1'b0;
    hold_done   = 1'b0;
    pixels_sent = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty image: a single white pixel, image end alone
    add_px(8'd255, 8'd7, 1'b0, 1'b1);
    send_image();
    // box at column 0, closed by the final column which has no column end
    add_px(8'd255, 8'd200, 1'b0, 1'b0); add_px(8'd0, 8'd0, 1'b1, 1'b0);
    add_px(8'd255, 8'd255, 1'b0, 1'b0); add_px(8'd255, 8'd1, 1'b0, 1'b1);
    send_image();
    // segment opens on the last column and is never closed
    add_px(8'd0, 8'd0, 1'b0, 1'b0); add_px(8'd0, 8'd0, 1'b1, 1'b1);
    send_image();
    // box with no raw black at all
    add_px(8'd0, 8'd255, 1'b0, 1'b0); add_px(8'd128, 8'd3, 1'b1, 1'b0);
    add_px(8'd255, 8'd255, 1'b0, 1'b0); add_px(8'd255, 8'd255, 1'b1, 1'b1);
    send_image();
    // raw black in the top row
    add_px(8'd0, 8'd0, 1'b0, 1'b0); add_px(8'd0, 8'd1, 1'b1, 1'b0);
    add_px(8'd255, 8'd9, 1'b0, 1'b0); add_px(8'd255, 8'd9, 1'b1, 1'b1);
    send_image();
    // gray pixel opens, raw black in the column before the start is counted
    add_px(8'd255, 8'd255, 1'b0, 1'b0); add_px(8'd255, 8'd0, 1'b1, 1'b0);
    add_px(8'd17, 8'd5, 1'b0, 1'b0);    add_px(8'd255, 8'd5, 1'b1, 1'b0);
    add_px(8'd0, 8'd40, 1'b0, 1'b0);    add_px(8'd254, 8'd0, 1'b1, 1'b0);
    add_px(8'd254, 8'd255, 1'b0, 1'b0); add_px(8'd255, 8'd255, 1'b1, 1'b1);
    send_image();

    // random images over three idling phases
    while (pixels_sent < PIXEL_TARGET) begin
      if (pixels_sent < PIXEL_TARGET / 3) begin
        send_idle = 10;
        recv_idle = 73;
      end else if (pixels_sent < 2 * PIXEL_TARGET / 3) begin
        send_idle = 73;
        recv_idle = 10;
      end else begin
        send_idle = 0;
        recv_idle = 0;
        if (!hold_done) begin
          // results held back while dense images keep coming, so the input backs up
          hold_done = 1'b1;
          hold_req  = 1'b1;
          repeat (2) begin
            build_text(SEG_LIMIT, SEG_LIMIT, 2, FLAW_NONE, 1'b0);
            send_image();
          end
        end
      end
      send_random_image();
    end

    in_valid = 1'b0;
    while (tracker.pending_boxes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0)
      $display("column_projection_segmenter_top regression: pass");
    else
      $display("column_projection_segmenter_top regression: fail");
    $finish;
  end

endmodule
